// File: src/tshl_pkg.sv
// ============================================================================
// Time-slotted history log: shared package
// Types and fixed constants of the slot log and its sample encoding.
// ============================================================================
`default_nettype none

package tshl_pkg;

  localparam logic [15:0] MISSING_CODE   = 16'hFFFF;
  localparam logic [15:0] CODE_MAX       = 16'hFFFE;
  localparam logic [15:0] CODE_OFFSET    = 16'd16384;
  localparam int          RESCAN_WINDOWS = 5;

  localparam logic REG_SLOT_SECONDS = 1'b0;

  typedef enum logic {
    CMD_ADD  = 1'b0,
    CMD_READ = 1'b1
  } cmd_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_PREP,
    S_DECIDE,
    S_CLEAR,
    S_RESCAN,
    S_FOLD,
    S_FILL,
    S_READ,
    S_RDATA,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

// File: src/tshl_ram.sv
// ============================================================================
// Time-slotted history log: generic RAM
// One write port and one read port with registered read data.
// ============================================================================
`default_nettype none

module tshl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: src/time_slotted_history_log_top.sv
// ============================================================================
// Time-slotted history log: top level
// Ring of temperature codes, one per interval, with published extrema.
// ============================================================================
// The log holds SLOTS 16-bit codes in one RAM with a registered read. After
// reset a clearing pass writes every slot as missing, during which no
// transaction is accepted on the input stream. A stale log adds a clearing
// sweep and then fills one slot. A due rescan adds a pass of RAM reads over
// every slot and may be followed by up to SLOTS fills. The sweep, rescan and
// fill all go through the single RAM port. One item is worked on at a time,
// and the next is taken while a result waits.
// ============================================================================
`default_nettype none

module time_slotted_history_log_top
  import tshl_pkg::*;
#(
  parameter int SLOTS = 128
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // temperature_q7[23:0], temperature_valid[24], time_seconds[56:25],
  // read_index[64:57], zero fill above
  input  wire logic [71:0] s_tdata,
  // command[0]
  input  wire logic [0:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // slot_code[15:0], slot_missing[16], low_code[32:17], high_code[48:33],
  // slots_written[56:49], log_cleared[57], zero fill above
  output logic      [63:0] m_tdata,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam int AW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int XW = ((CW > 8) ? CW : 8) + 1;

  state_t state, state_next;

  logic [15:0]   slot_seconds;
  logic [CW-1:0] cnt;
  logic [AW-1:0] wp;
  logic [31:0]   last_logged;
  logic [31:0]   last_rescan;
  logic [15:0]   running_low, running_high, shown_low, shown_high;
  logic [CW-1:0] scan_pos;
  logic [CW-1:0] written;
  logic          cleared;
  logic [15:0]   code;
  logic [15:0]   step;
  logic [32:0]   window, window5, diff_log, diff_rescan;
  logic [AW-1:0] phys;
  logic          in_range;
  logic          out_valid;
  logic [63:0]   out_data;

  cmd_t          cmd;
  logic [23:0]   temp;
  logic          temp_valid;
  logic [31:0]   now;
  logic [7:0]    idx;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [15:0]   ram_wdata, ram_rdata;

  logic [15:0]   f_code, base_low, base_high, fold_low, fold_high;
  logic          f_restart, f_publish, fold_en;

  logic          accept, clear_hit, rescan_hit, more, gap, load_out;
  logic [32:0]   fill_sum;
  logic [31:0]   fill_last;
  logic [15:0]   step_w, enc_code;
  logic [24:0]   enc_sum;
  logic [XW-1:0] idx_x, phys_sum, phys_w, scan_inc;
  logic          read_seq;

  tshl_ram #(.WIDTH(16), .DEPTH(SLOTS)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SLOT_SECONDS) ? {16'd0, slot_seconds} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_seconds <= 16'd120;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_SLOT_SECONDS) begin
      slot_seconds <= pwdata[15:0];
    end
  end

  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  assign step_w  = (slot_seconds == 16'd0) ? 16'd1 : slot_seconds;
  assign enc_sum = $signed({temp[23], temp}) + $signed({9'd0, CODE_OFFSET});

  always_comb begin
    if (!temp_valid) begin
      enc_code = MISSING_CODE;
    end else if (enc_sum[24]) begin
      enc_code = 16'd0;
    end else if (enc_sum[23:0] > {8'd0, CODE_MAX}) begin
      enc_code = CODE_MAX;
    end else begin
      enc_code = enc_sum[15:0];
    end
  end

  assign idx_x    = XW'(idx);
  assign phys_sum = idx_x + XW'(wp);
  assign phys_w   = (phys_sum >= XW'(SLOTS)) ? phys_sum - XW'(SLOTS) : phys_sum;
  assign scan_inc = XW'(scan_pos) + XW'(1);
  assign read_seq = in_range && (idx == 8'd0 || idx_x == scan_inc);

  assign clear_hit  = $signed(diff_log) > $signed(window);
  assign rescan_hit = $signed(diff_rescan) > $signed(window5);

  assign more      = now > last_logged;
  assign fill_sum  = {1'b0, last_logged} + {17'd0, step};
  assign gap       = {1'b0, now} > fill_sum;
  assign fill_last = fill_sum[32] ? 32'hFFFF_FFFF : fill_sum[31:0];

  always_comb begin
    f_code    = code;
    f_restart = 1'b0;
    f_publish = 1'b0;
    fold_en   = 1'b0;
    unique case (state)
      S_RESCAN: begin
        f_code    = ram_rdata;
        f_restart = (cnt == CW'(1));
        f_publish = (cnt == CW'(SLOTS));
        fold_en   = (cnt != '0);
      end
      S_FOLD: begin
        f_code    = code;
        f_restart = (scan_pos == '0);
        f_publish = (scan_inc == XW'(SLOTS));
        fold_en   = 1'b1;
      end
      S_RDATA: begin
        f_code    = ram_rdata;
        f_restart = (idx == 8'd0);
        f_publish = (idx_x + XW'(1) == XW'(SLOTS));
        fold_en   = read_seq;
      end
      default: begin
        fold_en = 1'b0;
      end
    endcase
    base_low  = f_restart ? MISSING_CODE : running_low;
    base_high = f_restart ? MISSING_CODE : running_high;
    fold_low  = base_low;
    fold_high = base_high;
    if (f_code != MISSING_CODE) begin
      if (base_low == MISSING_CODE || f_code < base_low) begin
        fold_low = f_code;
      end
      if (base_high == MISSING_CODE || f_code > base_high) begin
        fold_high = f_code;
      end
    end
  end

  always_comb begin
    ram_we     = 1'b0;
    ram_waddr  = AW'(cnt);
    ram_wdata  = MISSING_CODE;
    ram_raddr  = phys;
    state_next = state;
    load_out   = 1'b0;
    unique case (state)
      S_INIT: begin
        ram_we = 1'b1;
        if (cnt == CW'(SLOTS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        state_next = (cmd == CMD_READ) ? S_READ : S_DECIDE;
      end
      S_DECIDE: begin
        if (clear_hit) begin
          state_next = S_CLEAR;
        end else if (rescan_hit) begin
          state_next = S_RESCAN;
        end else begin
          state_next = S_FOLD;
        end
      end
      S_CLEAR: begin
        ram_we = 1'b1;
        if (cnt == CW'(SLOTS - 1)) begin
          state_next = S_FOLD;
        end
      end
      S_RESCAN: begin
        ram_raddr = AW'(cnt);
        if (cnt == CW'(SLOTS)) begin
          state_next = S_FOLD;
        end
      end
      S_FOLD: begin
        state_next = S_FILL;
      end
      S_FILL: begin
        if (more) begin
          ram_we    = 1'b1;
          ram_waddr = wp;
          ram_wdata = gap ? MISSING_CODE : code;
        end else begin
          state_next = S_DONE;
        end
      end
      S_READ: begin
        state_next = S_RDATA;
      end
      S_RDATA: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || m_tready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt          <= '0;
      wp           <= '0;
      last_logged  <= '0;
      last_rescan  <= '0;
      running_low  <= MISSING_CODE;
      running_high <= MISSING_CODE;
      shown_low    <= MISSING_CODE;
      shown_high   <= MISSING_CODE;
      scan_pos     <= '0;
      written      <= '0;
      out_valid    <= 1'b0;
    end else begin
      case (state)
        S_INIT, S_CLEAR, S_RESCAN: begin
          cnt <= cnt + CW'(1);
          if (state == S_RESCAN && cnt == CW'(SLOTS)) begin
            scan_pos <= CW'(SLOTS);
          end
        end
        S_IDLE: begin
          cnt <= '0;
        end
        S_PREP: begin
          written <= '0;
        end
        S_DECIDE: begin
          if (clear_hit) begin
            wp           <= '0;
            last_logged  <= now - 32'd1;
            running_low  <= MISSING_CODE;
            running_high <= MISSING_CODE;
            shown_low    <= MISSING_CODE;
            shown_high   <= MISSING_CODE;
            scan_pos     <= CW'(SLOTS);
          end
          if (rescan_hit) begin
            last_rescan <= now;
          end
        end
        S_FILL: begin
          if (more) begin
            wp          <= (wp == AW'(SLOTS - 1)) ? '0 : wp + AW'(1);
            written     <= written + CW'(1);
            last_logged <= fill_last;
          end
        end
        S_RDATA: begin
          if (read_seq) begin
            scan_pos <= CW'(idx);
          end
        end
        default: begin
          cnt <= cnt;
        end
      endcase
      if (fold_en) begin
        running_low  <= fold_low;
        running_high <= fold_high;
        if (f_publish) begin
          shown_low  <= fold_low;
          shown_high <= fold_high;
        end
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd        <= cmd_t'(s_tuser[0]);
      temp       <= s_tdata[23:0];
      temp_valid <= s_tdata[24];
      now        <= s_tdata[56:25];
      idx        <= s_tdata[64:57];
    end
    if (state == S_PREP) begin
      step        <= step_w;
      window      <= 33'(step_w) * 33'(SLOTS);
      window5     <= 33'(step_w) * 33'(SLOTS * RESCAN_WINDOWS);
      diff_log    <= {1'b0, now} - {1'b0, last_logged};
      diff_rescan <= {1'b0, now} - {1'b0, last_rescan};
      code        <= enc_code;
      phys        <= AW'(phys_w);
      in_range    <= idx_x < XW'(SLOTS);
      cleared     <= 1'b0;
    end
    if (state == S_DECIDE && clear_hit) begin
      cleared <= 1'b1;
    end
    if (state == S_RDATA) begin
      code <= in_range ? ram_rdata : MISSING_CODE;
    end
    if (load_out) begin
      out_data <= {6'd0, cleared, 8'(written), shown_high, shown_low,
                   (code == MISSING_CODE), code};
    end
  end

  assert property (@(posedge clk) disable iff (rst) wp <= AW'(SLOTS - 1))
    else $error("Write pointer left the ring.");

  assert property (@(posedge clk) disable iff (rst) scan_pos <= CW'(SLOTS))
    else $error("Scan position beyond the log.");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> (shown_low == MISSING_CODE && shown_high == MISSING_CODE))
    else $error("Extrema not reset while clearing a stale log.");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && cmd == CMD_ADD && cleared) |-> (written == CW'(1)))
    else $error("Add after a clear did not fill exactly one slot.");

endmodule

`default_nettype wire

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// Time-slotted history log: testbench
// Drives timed samples and slot reads into the log over the input stream and
// writes the slot interval over the register port. A predictor keeps its own
// copy of the slot ring and extrema, and every output transaction is checked
// field by field against the oldest pending prediction. Sender and receiver
// idle at random in phases, and the receiver also holds off for long stretches.
// ============================================================================

module tb_top;
  import tshl_pkg::*;

  localparam int     LOG_SLOTS    = 128;
  localparam longint TIME_CEILING = 64'h0000_0000_FFFF_FFFF;
  localparam int     MAX_REPORTS  = 10;

  typedef struct {
    cmd_t        command;
    logic [23:0] temp_q7;
    logic        temp_valid;
    logic [31:0] time_sec;
    logic [7:0]  read_index;
  } log_item_t;

  typedef struct {
    logic [15:0] slot_code;
    logic        slot_missing;
    logic [15:0] low_code;
    logic [15:0] high_code;
    logic [7:0]  slots_written;
    logic        log_cleared;
  } log_result_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  wire         s_tready;
  logic [71:0] s_tdata;
  logic [0:0]  s_tuser;
  wire         m_tvalid;
  logic        m_tready = 1'b0;
  wire  [63:0] m_tdata;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  wire  [31:0] prdata;
  wire         pready;

  logic [15:0] slot_mem [LOG_SLOTS];
  int          fill_ptr;
  int          scan_idx;
  logic [31:0] logged_time;
  logic [31:0] rescan_time;
  logic [15:0] run_low;
  logic [15:0] run_high;
  logic [15:0] pub_low;
  logic [15:0] pub_high;
  logic [15:0] interval_sec;

  log_result_t pending_responses [$];

  int          items_sent = 0;
  int          adds_sent = 0;
  int          reads_sent = 0;
  int          clears_expected = 0;
  int          fills_expected = 0;
  int          responses_checked = 0;
  int          mismatch_count = 0;
  int          interval_settings = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_off_left = 0;
  logic [31:0] time_cursor;

  time_slotted_history_log_top #(
    .SLOTS(LOG_SLOTS)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [15:0] encode_temperature(logic [23:0] raw, logic valid);
    int t;
    if (!valid) return MISSING_CODE;
    t = int'($signed(raw)) + int'(CODE_OFFSET);
    if (t < 0) t = 0;
    if (t > int'(CODE_MAX)) t = int'(CODE_MAX);
    return 16'(t);
  endfunction

  function automatic void fold_into_extrema(logic [15:0] code);
    if (scan_idx == 0) begin
      run_low = MISSING_CODE;
      run_high = MISSING_CODE;
    end
    if (code != MISSING_CODE) begin
      if (run_low == MISSING_CODE || code < run_low) run_low = code;
      if (run_high == MISSING_CODE || code > run_high) run_high = code;
    end
    if (scan_idx + 1 == LOG_SLOTS) begin
      pub_low = run_low;
      pub_high = run_high;
    end
  endfunction

  function automatic void rescan_extrema();
    for (scan_idx = 0; scan_idx < LOG_SLOTS; scan_idx++) fold_into_extrema(slot_mem[scan_idx]);
  endfunction

  function automatic log_result_t compute_log_response(log_item_t it);
    log_result_t r;
    longint      now_s;
    longint      step_s;
    longint      window_s;
    longint      last_s;
    int          phys;
    r.slot_code = MISSING_CODE;
    r.slots_written = 8'd0;
    r.log_cleared = 1'b0;
    if (it.command == CMD_ADD) begin
      now_s = longint'(it.time_sec);
      step_s = (interval_sec == 16'd0) ? 1 : longint'(interval_sec);
      window_s = LOG_SLOTS * step_s;
      if (now_s - longint'(logged_time) > window_s) begin
        foreach (slot_mem[k]) slot_mem[k] = MISSING_CODE;
        fill_ptr = 0;
        rescan_extrema();
        logged_time = it.time_sec - 32'd1;
        r.log_cleared = 1'b1;
      end
      if (now_s - longint'(rescan_time) > RESCAN_WINDOWS * window_s) begin
        rescan_extrema();
        rescan_time = it.time_sec;
      end
      r.slot_code = encode_temperature(it.temp_q7, it.temp_valid);
      fold_into_extrema(r.slot_code);
      last_s = longint'(logged_time);
      while (now_s > last_s) begin
        slot_mem[fill_ptr] = (now_s > last_s + step_s) ? MISSING_CODE : r.slot_code;
        fill_ptr = (fill_ptr + 1) % LOG_SLOTS;
        r.slots_written++;
        last_s += step_s;
        if (last_s > TIME_CEILING) last_s = TIME_CEILING;
      end
      logged_time = last_s[31:0];
    end else begin
      if (int'(it.read_index) < LOG_SLOTS) begin
        phys = (int'(it.read_index) + fill_ptr) % LOG_SLOTS;
        r.slot_code = slot_mem[phys];
        if (it.read_index == 8'd0 || int'(it.read_index) == scan_idx + 1) begin
          scan_idx = int'(it.read_index);
          fold_into_extrema(r.slot_code);
        end
      end
    end
    r.slot_missing = (r.slot_code == MISSING_CODE);
    r.low_code = pub_low;
    r.high_code = pub_high;
    return r;
  endfunction

  function automatic int unsigned current_step();
    return (interval_sec == 16'd0) ? 32'd1 : 32'(interval_sec);
  endfunction

  function automatic logic [23:0] random_temperature();
    return 24'(int'($urandom_range(70000)) - 22000);
  endfunction

  always @(negedge clk) begin
    if (hold_off_left > 0) begin
      hold_off_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic check_response(input logic [63:0] word);
    log_result_t got;
    log_result_t want;
    got.slot_code = word[15:0];
    got.slot_missing = word[16];
    got.low_code = word[32:17];
    got.high_code = word[48:33];
    got.slots_written = word[56:49];
    got.log_cleared = word[57];
    if (pending_responses.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) $display("Result with nothing pending: %h", word);
    end else begin
      want = pending_responses.pop_front();
      responses_checked++;
      if (got.slot_code !== want.slot_code || got.slot_missing !== want.slot_missing ||
          got.low_code !== want.low_code || got.high_code !== want.high_code ||
          got.slots_written !== want.slots_written || got.log_cleared !== want.log_cleared) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("Mismatch at result %0d: expected code %h missing %b low %h high %h written %0d cleared %b",
                   responses_checked, want.slot_code, want.slot_missing, want.low_code,
                   want.high_code, want.slots_written, want.log_cleared);
          $display("  got code %h missing %b low %h high %h written %0d cleared %b",
                   got.slot_code, got.slot_missing, got.low_code, got.high_code,
                   got.slots_written, got.log_cleared);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) check_response(m_tdata);
  end

  task automatic send_item(input log_item_t it);
    log_result_t r;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {7'b0, it.read_index, it.time_sec, it.temp_valid, it.temp_q7};
    s_tuser <= it.command;
    do @(posedge clk); while (!s_tready);
    r = compute_log_response(it);
    pending_responses.push_back(r);
    items_sent++;
    if (it.command == CMD_ADD) adds_sent++;
    else reads_sent++;
    if (r.log_cleared) clears_expected++;
    fills_expected += int'(r.slots_written);
  endtask

  task automatic send_add(input logic [23:0] temp, input logic valid, input logic [31:0] t);
    log_item_t it;
    it.command = CMD_ADD;
    it.temp_q7 = temp;
    it.temp_valid = valid;
    it.time_sec = t;
    it.read_index = 8'($urandom());
    send_item(it);
  endtask

  task automatic send_read(input logic [7:0] idx);
    log_item_t it;
    it.command = CMD_READ;
    it.temp_q7 = 24'($urandom());
    it.temp_valid = 1'($urandom());
    it.time_sec = $urandom();
    it.read_index = idx;
    send_item(it);
  endtask

  task automatic send_reading_run(input int count, input int unsigned max_delta);
    repeat (count) begin
      time_cursor += $urandom_range(max_delta);
      send_add(random_temperature(), $urandom_range(9) != 0, time_cursor);
    end
  endtask

  task automatic send_read_sweep(input int first, input int last);
    for (int i = first; i <= last; i++) send_read(8'(i));
  endtask

  task automatic drain_responses();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_slot_seconds(input logic [15:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_SLOT_SECONDS, 2'b00};
    pwdata <= {16'b0, value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    interval_sec = value;
    interval_settings++;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic test_directed_cases();
    send_read(8'd0);
    send_read(8'd127);
    send_read(8'd128);
    send_read(8'd255);
    send_add(24'h7FFFFF, 1'b1, 32'd1000);
    send_add(24'h800000, 1'b1, 32'd1100);
    send_add(24'd0, 1'b1, 32'd1300);
    send_add(24'($urandom()), 1'b0, 32'd1500);
    send_add(24'd49150, 1'b1, 32'd1620);
    send_add(24'(-16385), 1'b1, 32'd1740);
    send_add(24'(-16384), 1'b1, 32'd1860);
    send_add(24'd49151, 1'b1, 32'd500);
    send_add(random_temperature(), 1'b1, 32'd1860);
    send_add(random_temperature(), 1'b1, 32'd17220);
    send_add(random_temperature(), 1'b1, 32'd40000);
    send_add(random_temperature(), 1'b1, 32'd120000);
    send_read(8'd0);
    send_read(8'd1);
    send_read(8'd2);
    send_read(8'd9);
    send_read(8'd3);
    send_read(8'd0);
    time_cursor = 32'd120000;
  endtask

  task automatic test_interval_extremes();
    logic [15:0] settings [3];
    settings = '{16'd0, 16'd1, 16'hFFFF};
    foreach (settings[k]) begin
      drain_responses();
      write_slot_seconds(settings[k]);
      send_reading_run(6, 3 * current_step());
      send_read_sweep(0, 5);
      time_cursor += (LOG_SLOTS + 1) * current_step();
      send_add(random_temperature(), 1'b1, time_cursor);
      send_read(8'd0);
    end
  endtask

  task automatic test_random_traffic();
    int          idle_of [4];
    int          stall_of [4];
    logic [15:0] interval_of [4];
    int          r;
    int          start;
    int unsigned step;
    int unsigned window;
    int unsigned amount;
    idle_of = '{0, 52, 0, 29};
    stall_of = '{0, 0, 52, 29};
    interval_of = '{16'd120, 16'd1, 16'hFFFF, 16'($urandom_range(2, 900))};
    for (int p = 0; p < 4; p++) begin
      drain_responses();
      write_slot_seconds(interval_of[p]);
      send_idle_pct = idle_of[p];
      recv_stall_pct = stall_of[p];
      start = items_sent;
      while (items_sent - start < 280) begin
        step = current_step();
        window = LOG_SLOTS * step;
        r = $urandom_range(99);
        if (r < 40) begin
          send_reading_run($urandom_range(1, 8), 2 * step);
        end else if (r < 44) begin
          if ($urandom_range(3) == 0) send_read_sweep(0, LOG_SLOTS - 1);
          else send_read_sweep(0, $urandom_range(1, 30));
        end else if (r < 48) begin
          amount = $urandom_range(1, 120);
          send_read_sweep(amount, amount + $urandom_range(12));
        end else if (r < 60) begin
          send_read(8'($urandom()));
        end else if (r < 70) begin
          time_cursor += $urandom_range(step);
          send_add(24'($urandom()), 1'($urandom()), time_cursor);
        end else if (r < 78) begin
          amount = $urandom_range(4 * step);
          if (amount > time_cursor) amount = time_cursor;
          send_add(random_temperature(), 1'b1, time_cursor - amount);
        end else if (r < 88) begin
          time_cursor += $urandom_range(8 * step, window);
          send_add(random_temperature(), 1'b1, time_cursor);
        end else if (r < 95 && time_cursor < 32'hC000_0000) begin
          time_cursor += $urandom_range(window + 1, 7 * window);
          send_add(random_temperature(), 1'b1, time_cursor);
        end else begin
          send_reading_run(1, 0);
        end
      end
    end
  endtask

  task automatic test_output_backpressure();
    drain_responses();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_left = 300;
    send_reading_run(6, current_step());
    send_read_sweep(0, 9);
    drain_responses();
    send_idle_pct = 29;
    recv_stall_pct = 29;
    hold_off_left = 150;
    send_reading_run(4, 2 * current_step());
    send_read_sweep(0, LOG_SLOTS - 1);
    drain_responses();
  endtask

  task automatic test_time_ceiling();
    drain_responses();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_slot_seconds(16'd120);
    send_add(random_temperature(), 1'b1, 32'hFFFF_FFFE);
    send_add(random_temperature(), 1'b1, 32'hFFFF_FFFF);
    send_add(24'($urandom()), 1'b0, 32'hFFFF_FFFF);
    send_read_sweep(0, LOG_SLOTS - 1);
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    time_cursor = '0;
    foreach (slot_mem[k]) slot_mem[k] = MISSING_CODE;
    fill_ptr = 0;
    scan_idx = 0;
    logged_time = '0;
    rescan_time = '0;
    run_low = MISSING_CODE;
    run_high = MISSING_CODE;
    pub_low = MISSING_CODE;
    pub_high = MISSING_CODE;
    interval_sec = 16'd120;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_interval_extremes();
    test_random_traffic();
    test_output_backpressure();
    test_time_ceiling();

    drain_responses();
    repeat (2 * LOG_SLOTS) @(posedge clk);
    $display("Run covered %0d adds and %0d reads, with %0d slot fills and %0d stale-log clears,",
             adds_sent, reads_sent, fills_expected, clears_expected);
    $display("across %0d interval settings; %0d results compared, %0d mismatches.",
             interval_settings, responses_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Timeout with %0d results still pending.", pending_responses.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
